FILE: hw/rtl/cfdos_pkg.sv
// Shared constants, tables, types and helpers of the CFD off-target scorer.
`timescale 1ns / 1ps

package cfdos_pkg;

  // Fixed-point format, unsigned Q1.16
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned Q_W        = FRAC_BITS + 1;
  localparam int unsigned SCORE_W    = 17;
  localparam logic [Q_W-1:0] ONE_Q   = Q_W'(1) << FRAC_BITS;

  // Spacer positions and the saturating pair counter
  localparam int unsigned SPACER_MAX = 20;
  localparam int unsigned POS_W      = 5;
  localparam logic [POS_W-1:0] POS_SAT = '1;

  // Mismatch table, only off-diagonal (guide != target) entries are kept
  localparam int unsigned MM_ROWS    = 20;
  localparam int unsigned MM_COLS    = 12;
  localparam int unsigned MM_ENTRIES = MM_ROWS * MM_COLS;
  localparam int unsigned MM_IDX_W   = $clog2(MM_ENTRIES);
  localparam int unsigned PAM_ENTRIES = 16;
  localparam int unsigned PAM_IDX_W   = $clog2(PAM_ENTRIES);

  // Base codes
  localparam int unsigned BASE_W = 3;
  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T = 3'd3;
  localparam logic [BASE_W-1:0] BASE_X = 3'd4;

  // ASCII codes used by the decoder
  localparam logic [7:0] CHR_LOW_A = 8'h61;
  localparam logic [7:0] CHR_LOW_Z = 8'h7a;
  localparam logic [7:0] CHR_CASE  = 8'h20;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_C     = 8'h43;
  localparam logic [7:0] CHR_G     = 8'h47;
  localparam logic [7:0] CHR_T     = 8'h54;

  // Table values in millionths, turned into Q format at elaboration
  localparam logic [63:0] MICRO_W = 64'd1000000;

  localparam int unsigned MM_MICRO [MM_ROWS*16] = '{
    1000000,857143,1000000,1000000, 1000000,1000000,913043,1000000,
    900000,714286,1000000,1000000, 1000000,857143,956522,1000000,
    1000000,785714,800000,727273, 727273,1000000,695652,909091,
    846154,692308,1000000,636364, 846154,857143,840000,1000000,
    1000000,428571,611111,705882, 866667,1000000,500000,687500,
    750000,384615,1000000,500000, 714286,428571,500000,1000000,
    1000000,352941,625000,636364, 842105,1000000,500000,800000,
    900000,529412,1000000,363636, 476190,647059,625000,1000000,
    1000000,500000,720000,363636, 571429,1000000,600000,636364,
    866667,785714,1000000,300000, 500000,1000000,640000,1000000,
    1000000,454545,714286,714286, 928571,1000000,500000,928571,
    1000000,681818,1000000,666667, 866667,909091,571429,1000000,
    1000000,437500,705882,437500, 750000,1000000,470588,812500,
    1000000,687500,1000000,571429, 875000,687500,588235,1000000,
    1000000,428571,733333,428571, 650000,1000000,642857,875000,
    1000000,615385,1000000,625000, 800000,1000000,733333,1000000,
    1000000,571429,666667,600000, 857143,1000000,619048,875000,
    642857,538462,1000000,533333, 928571,923077,619048,1000000,
    1000000,333333,555556,882353, 866667,1000000,388889,941176,
    933333,400000,1000000,812500, 857143,533333,500000,1000000,
    1000000,400000,650000,307692, 750000,1000000,250000,307692,
    1000000,428571,1000000,384615, 750000,666667,400000,1000000,
    1000000,263158,722222,333333, 714286,1000000,444444,538462,
    933333,529412,1000000,384615, 800000,947368,500000,1000000,
    1000000,210526,652174,300000, 384615,1000000,136364,700000,
    923077,421053,1000000,300000, 692308,789474,260870,1000000,
    1000000,214286,466667,533333, 350000,1000000,0,733333,
    750000,428571,1000000,266667, 619048,285714,0,1000000,
    1000000,272727,650000,200000, 222222,1000000,50000,66667,
    941176,272727,1000000,142857, 578947,272727,50000,1000000,
    1000000,0,192308,0, 1000000,1000000,153846,307692,
    1000000,0,1000000,0, 909091,666667,346154,1000000,
    1000000,176471,176471,133333, 466667,1000000,58824,466667,
    933333,235294,1000000,250000, 533333,705882,117647,1000000,
    1000000,190476,400000,500000, 538462,1000000,133333,642857,
    692308,476190,1000000,666667, 666667,428571,333333,1000000,
    1000000,206897,375000,538462, 428571,1000000,125000,461538,
    714286,448276,1000000,666667, 285714,275862,250000,1000000,
    1000000,227273,764706,600000, 500000,1000000,58824,300000,
    937500,428571,1000000,700000, 562500,90909,176471,1000000
  };

  localparam int unsigned PAM_MICRO [PAM_ENTRIES] = '{
    0, 0, 259000, 0,
    0, 0, 107000, 0,
    69000, 22000, 1000000, 16000,
    0, 0, 39000, 0
  };

  typedef logic [Q_W-1:0] mm_rom_t  [MM_ENTRIES];
  typedef logic [Q_W-1:0] pam_rom_t [PAM_ENTRIES];

  // Millionths to Q format, round to nearest with ties up
  function automatic logic [Q_W-1:0] to_q(input int unsigned micro);
    logic [63:0] w;
    w = ((64'(micro) << FRAC_BITS) + (MICRO_W >> 1)) / MICRO_W;
    return w[Q_W-1:0];
  endfunction

  function automatic mm_rom_t build_mm();
    mm_rom_t rom;
    int unsigned k;
    k = 0;
    for (int unsigned p = 0; p < MM_ROWS; p++) begin
      for (int unsigned g = 0; g < 4; g++) begin
        for (int unsigned t = 0; t < 4; t++) begin
          if (g != t) begin
            rom[k] = to_q(MM_MICRO[p*16 + g*4 + t]);
            k++;
          end
        end
      end
    end
    return rom;
  endfunction

  function automatic pam_rom_t build_pam();
    pam_rom_t rom;
    for (int unsigned i = 0; i < PAM_ENTRIES; i++) begin
      rom[i] = to_q(PAM_MICRO[i]);
    end
    return rom;
  endfunction

  localparam mm_rom_t  MM_Q  = build_mm();
  localparam pam_rom_t PAM_Q = build_pam();

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MM,
    S_PAM
  } state_e;

  // Operand control for the shared multiplier
  typedef struct packed {
    logic                 sel_pam;
    logic                 mm_apply;
    logic [MM_IDX_W-1:0]  mm_idx;
    logic                 pam_ok;
    logic [PAM_IDX_W-1:0] pam_idx;
  } op_t;

  // ASCII upper-case, a..z only
  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CHR_LOW_A && c <= CHR_LOW_Z) begin
      return c - CHR_CASE;
    end
    return c;
  endfunction

  function automatic logic [BASE_W-1:0] base_code(input logic [7:0] u);
    case (u)
      CHR_A:   return BASE_A;
      CHR_C:   return BASE_C;
      CHR_G:   return BASE_G;
      CHR_T:   return BASE_T;
      default: return BASE_X;
    endcase
  endfunction

  // Packed row index: pos * 12 + g * 3 + (t with the diagonal skipped)
  function automatic logic [MM_IDX_W-1:0] mm_index(input logic [POS_W-1:0] pos,
                                                   input logic [1:0] g,
                                                   input logic [1:0] t);
    logic [MM_IDX_W-1:0] row;
    logic [MM_IDX_W-1:0] col;
    logic [1:0]          tc;
    row = (MM_IDX_W'(pos) << 3) + (MM_IDX_W'(pos) << 2);
    tc  = (t > g) ? t - 2'd1 : t;
    col = (MM_IDX_W'(g) << 1) + MM_IDX_W'(g) + MM_IDX_W'(tc);
    return row + col;
  endfunction

endpackage

FILE: hw/rtl/cfdos_if.sv
// Valid/ready channel interfaces for the input pairs and the score words.
`timescale 1ns / 1ps

interface cfdos_in_if;
  logic       valid;
  logic       ready;
  logic       pair_present;
  logic [7:0] guide_char;
  logic [7:0] target_char;
  logic [7:0] pam_first;
  logic [7:0] pam_second;
  logic       pam_complete;
  logic       has_indel;
  logic       last;

  modport source (
    output valid, pair_present, guide_char, target_char, pam_first, pam_second,
           pam_complete, has_indel, last,
    input  ready
  );
  modport sink (
    input  valid, pair_present, guide_char, target_char, pam_first, pam_second,
           pam_complete, has_indel, last,
    output ready
  );
endinterface

interface cfdos_out_if;
  logic                         valid;
  logic                         ready;
  logic [cfdos_pkg::SCORE_W-1:0] score;

  modport source (
    output valid, score,
    input  ready
  );
  modport sink (
    input  valid, score,
    output ready
  );
endinterface

FILE: hw/rtl/cfdos_qmul.sv
// Shared Q1.16 multiplier with its factor selection from the penalty tables.
`timescale 1ns / 1ps

module cfdos_qmul (
  input  cfdos_pkg::op_t               op_i,
  input  logic [cfdos_pkg::Q_W-1:0]    acc_i,
  output logic [cfdos_pkg::Q_W-1:0]    prod_o
);

  logic [cfdos_pkg::Q_W-1:0]   factor;
  logic [2*cfdos_pkg::Q_W-1:0] full;

  // Factor: PAM entry or zero on the final step, mismatch entry or 1.0 otherwise
  always_comb begin
    if (op_i.sel_pam) begin
      factor = op_i.pam_ok ? cfdos_pkg::PAM_Q[op_i.pam_idx] : '0;
    end else begin
      factor = op_i.mm_apply ? cfdos_pkg::MM_Q[op_i.mm_idx] : cfdos_pkg::ONE_Q;
    end
  end

  // Truncating product
  assign full   = (2*cfdos_pkg::Q_W)'(acc_i) * (2*cfdos_pkg::Q_W)'(factor);
  assign prod_o = full[cfdos_pkg::FRAC_BITS +: cfdos_pkg::Q_W];

endmodule

FILE: hw/rtl/cfd_offtarget_scorer.sv
// Top level of the CFD off-target scorer: decoder, sequencer and score register.
// Each pair word is accepted in idle, then multiplied by its mismatch factor.
// A last word: accept, mismatch, then the PAM multiply, which waits for a free
// score register. All share the single multiplier; input ready only in idle.
// The score register frees the input side while a score waits to be taken.
// Reset (asynchronous, active low) sets the product to 1.0 and clears counters.
`timescale 1ns / 1ps

module cfd_offtarget_scorer (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfdos_in_if.sink      in_i,
  cfdos_out_if.source   out_o
);

  cfdos_pkg::state_e                 state_q, state_d;
  cfdos_pkg::op_t                    op_q, op_d;
  logic [cfdos_pkg::Q_W-1:0]         prod_q, prod_d;
  logic [cfdos_pkg::POS_W-1:0]       pos_q, pos_d;
  logic                              seen_q, seen_d;
  logic                              last_q, last_d;
  logic                              out_valid_q, out_valid_d;
  logic [cfdos_pkg::SCORE_W-1:0]     score_q, score_d;
  logic [cfdos_pkg::Q_W-1:0]         mul_out;

  logic [7:0]                        g_up, t_up;
  logic [cfdos_pkg::BASE_W-1:0]      gi, ti, p1, p2;
  logic                              seen_n;

  cfdos_qmul u_qmul (
    .op_i   (op_q),
    .acc_i  (prod_q),
    .prod_o (mul_out)
  );

  assign in_i.ready  = (state_q == cfdos_pkg::S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.score = score_q;

  // Base decoding of the incoming word
  always_comb begin
    g_up   = cfdos_pkg::upcase(in_i.guide_char);
    t_up   = cfdos_pkg::upcase(in_i.target_char);
    gi     = cfdos_pkg::base_code(g_up);
    ti     = cfdos_pkg::base_code(t_up);
    p1     = cfdos_pkg::base_code(cfdos_pkg::upcase(in_i.pam_first));
    p2     = cfdos_pkg::base_code(cfdos_pkg::upcase(in_i.pam_second));
    seen_n = seen_q | in_i.pair_present;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    prod_d      = prod_q;
    pos_d       = pos_q;
    seen_d      = seen_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    score_d     = score_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      cfdos_pkg::S_IDLE: begin
        if (in_i.valid) begin
          // N and other letters decode to BASE_X and count as a match
          op_d.sel_pam  = 1'b0;
          op_d.mm_apply = in_i.pair_present &&
                          (32'(pos_q) < cfdos_pkg::SPACER_MAX) &&
                          (gi != cfdos_pkg::BASE_X) && (ti != cfdos_pkg::BASE_X) &&
                          (gi != ti);
          op_d.mm_idx   = op_d.mm_apply ? cfdos_pkg::mm_index(pos_q, gi[1:0], ti[1:0])
                                        : '0;
          op_d.pam_ok   = !in_i.has_indel && in_i.pam_complete && seen_n &&
                          (p1 != cfdos_pkg::BASE_X) && (p2 != cfdos_pkg::BASE_X);
          op_d.pam_idx  = {p1[1:0], p2[1:0]};
          if (in_i.pair_present && (pos_q != cfdos_pkg::POS_SAT)) begin
            pos_d = pos_q + cfdos_pkg::POS_W'(1);
          end
          seen_d  = seen_n;
          last_d  = in_i.last;
          state_d = cfdos_pkg::S_MM;
        end
      end
      cfdos_pkg::S_MM: begin
        prod_d = mul_out;
        if (last_q) begin
          op_d.sel_pam = 1'b1;
          state_d      = cfdos_pkg::S_PAM;
        end else begin
          state_d = cfdos_pkg::S_IDLE;
        end
      end
      cfdos_pkg::S_PAM: begin
        // Wait for the score register, then finish the run
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          score_d     = cfdos_pkg::SCORE_W'(mul_out);
          prod_d      = cfdos_pkg::ONE_Q;
          pos_d       = '0;
          seen_d      = 1'b0;
          state_d     = cfdos_pkg::S_IDLE;
        end
      end
      default: state_d = cfdos_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfdos_pkg::S_IDLE;
      prod_q      <= cfdos_pkg::ONE_Q;
      pos_q       <= '0;
      seen_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prod_q      <= prod_d;
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    score_q <= score_d;
  end

endmodule

FILE: hw/rtl/cfdos_checker.sv
// Port-level checks of the scorer and their bind to the top level.
`timescale 1ns / 1ps

module cfdos_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_last_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [cfdos_pkg::SCORE_W-1:0] out_score_i
);

  localparam logic [cfdos_pkg::SCORE_W-1:0] SCORE_ONE =
    cfdos_pkg::SCORE_W'(cfdos_pkg::ONE_Q);

  // A score never exceeds 1.0
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_score_i <= SCORE_ONE))
    else $error("score above 1.0");

  // The shared multiplier is busy the cycle after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while multiplier busy");

  // A word that is not last produces no score
  a_no_score_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_last_i) |=> !$rose(out_valid_i))
    else $error("score raised by a word that is not last");

  // A stalled score word holds
  a_score_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_score_i)))
    else $error("stalled score word changed");

endmodule

bind cfd_offtarget_scorer cfdos_checker u_cfdos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_score_i (out_o.score)
);
